@@ rtl/brb_pkg.sv @@
// Shared constants for the byte ring buffer with bulk operations:
// field widths, operation codes and default sizes. No dependencies.
`default_nettype none

package brb_pkg;

    // Field widths
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 10;

    // Default sizes
    localparam int DEPTH_DEF   = 1024;
    localparam int MAX_POP_DEF = 64;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd3;

endpackage

`default_nettype wire

@@ rtl/brb_ram.sv @@
// Byte store: one write port and one read port, read data registered.
// Depends on brb_pkg for the byte width.
`default_nettype none

module brb_ram #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [PTR_W-1:0]          waddr,
    input  wire logic [brb_pkg::BYTE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [PTR_W-1:0]          raddr,
    output logic      [brb_pkg::BYTE_W-1:0] rdata
);
    import brb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    // Write a byte
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read a byte; hold the data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/byte_ring_buffer_bulk_ops_unit.sv @@
// Push, discard, flush and empty pop give their one result in the output register in
// the cycle after acceptance; a pop of n bytes passes each byte through the store's
// registered read and then the output register, one a cycle while results are taken.
// One single-result item is accepted per cycle; a pop of n bytes holds the input until
// its final byte is loaded. A result that is not taken holds the input until it is.
// Reset clears the pointers, the group flag and the output valid; the store is
// not cleared, and only entries already written are ever read.
`default_nettype none

module byte_ring_buffer_bulk_ops_unit #(
    parameter int DEPTH   = brb_pkg::DEPTH_DEF,
    parameter int MAX_POP = brb_pkg::MAX_POP_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [brb_pkg::KIND_W-1:0] kind,
    input  wire logic [brb_pkg::BYTE_W-1:0] data_in,
    input  wire logic                       group_start,
    input  wire logic [brb_pkg::CNT_W-1:0]  group_len,
    input  wire logic [brb_pkg::CNT_W-1:0]  count,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [brb_pkg::BYTE_W-1:0] data_out,
    output logic                            data_valid,
    output logic                            accepted,
    output logic      [brb_pkg::CNT_W-1:0]  moved_count,
    output logic      [brb_pkg::CNT_W-1:0]  free_space,
    output logic                            last
);
    import brb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int W     = (PTR_W > CNT_W) ? PTR_W + 1 : CNT_W + 1;
    localparam int POP_W = $clog2(MAX_POP + 1);

    localparam logic [W-1:0]     DEPTH_W   = W'(DEPTH);
    localparam logic [W-1:0]     FULL_FREE = W'(DEPTH - 1);
    localparam logic [W-1:0]     MAXPOP_W  = W'(MAX_POP);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    // Control state
    logic             state_reg, state_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic             gok_reg, gok_next;
    logic [POP_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] pmoved_reg, pmoved_next;
    logic [CNT_W-1:0] pfree_reg, pfree_next;
    logic             out_valid_reg, out_valid_next;

    // Output payload
    logic [BYTE_W-1:0] data_out_reg;
    logic              data_valid_reg;
    logic              accepted_reg;
    logic [CNT_W-1:0]  moved_reg;
    logic [CNT_W-1:0]  free_reg;
    logic              last_reg;

    // Result being loaded
    logic              out_load;
    logic [BYTE_W-1:0] o_data;
    logic              o_dvalid;
    logic              o_acc;
    logic [CNT_W-1:0]  o_moved;
    logic [CNT_W-1:0]  o_free;
    logic              o_last;

    // Store ports
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    // Arithmetic
    logic [W-1:0]     wptr_w, rptr_w, glen_w, cnt_w;
    logic [W-1:0]     in_use_w, free_w;
    logic [W-1:0]     n_use_w, pop_n_w, disc_sum_w, disc_ptr_w;
    logic [W-1:0]     push_free_w, pop_free_w, disc_free_w;
    logic [POP_W-1:0] pop_n;
    logic             gok_new, push_store;
    logic [PTR_W-1:0] wptr_inc, rptr_inc;
    logic             out_free, in_fire;

    brb_ram #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (data_in),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    // Handshake
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    // Occupancy and free space
    assign wptr_w   = W'(wptr_reg);
    assign rptr_w   = W'(rptr_reg);
    assign glen_w   = W'(group_len);
    assign cnt_w    = W'(count);
    assign in_use_w = (wptr_w >= rptr_w) ? (wptr_w - rptr_w) : (wptr_w + DEPTH_W - rptr_w);
    assign free_w   = FULL_FREE - in_use_w;

    // Push decision
    assign gok_new     = group_start ? ((group_len != '0) && (glen_w <= free_w)) : gok_reg;
    assign push_store  = gok_new && (free_w != '0);
    assign push_free_w = push_store ? (free_w - W'(1)) : free_w;

    // Pop and discard sizes
    assign n_use_w     = (cnt_w > in_use_w) ? in_use_w : cnt_w;
    assign pop_n_w     = (n_use_w > MAXPOP_W) ? MAXPOP_W : n_use_w;
    assign pop_n       = pop_n_w[POP_W-1:0];
    assign pop_free_w  = free_w + pop_n_w;
    assign disc_free_w = free_w + n_use_w;
    assign disc_sum_w  = rptr_w + n_use_w;
    assign disc_ptr_w  = (disc_sum_w >= DEPTH_W) ? (disc_sum_w - DEPTH_W) : disc_sum_w;

    // Pointer wrap
    assign wptr_inc = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
    assign rptr_inc = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);

    // Sequencer: push, discard, flush and an empty pop finish at once; other pops stream from the store.
    // Writes happen only in idle and reads only from entries behind the write
    // pointer, so the two ports never touch the same entry in one cycle.
    always_comb
    begin
        state_next  = state_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        gok_next    = gok_reg;
        rem_next    = rem_reg;
        pmoved_next = pmoved_reg;
        pfree_next  = pfree_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        out_load    = 1'b0;
        o_data      = '0;
        o_dvalid    = 1'b0;
        o_acc       = 1'b1;
        o_moved     = '0;
        o_free      = free_w[CNT_W-1:0];
        o_last      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind)
                        KIND_PUSH:
                        begin
                            gok_next = gok_new;
                            out_load = 1'b1;
                            o_acc    = push_store;
                            o_free   = push_free_w[CNT_W-1:0];
                            if (push_store)
                            begin
                                ram_we    = 1'b1;
                                wptr_next = wptr_inc;
                            end
                        end
                        KIND_POP:
                        begin
                            if (pop_n == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                rptr_next   = rptr_inc;
                                rem_next    = pop_n - POP_W'(1);
                                pmoved_next = CNT_W'(pop_n);
                                pfree_next  = pop_free_w[CNT_W-1:0];
                                state_next  = S_EMIT;
                            end
                        end
                        KIND_DISCARD:
                        begin
                            rptr_next = disc_ptr_w[PTR_W-1:0];
                            out_load  = 1'b1;
                            o_moved   = n_use_w[CNT_W-1:0];
                            o_free    = disc_free_w[CNT_W-1:0];
                        end
                        default:
                        begin
                            wptr_next = '0;
                            rptr_next = '0;
                            gok_next  = 1'b0;
                            out_load  = 1'b1;
                            o_free    = FULL_FREE[CNT_W-1:0];
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    o_data   = ram_rdata;
                    o_dvalid = 1'b1;
                    o_moved  = pmoved_reg;
                    o_free   = pfree_reg;
                    o_last   = (rem_reg == '0);
                    if (rem_reg != '0)
                    begin
                        ram_re    = 1'b1;
                        rptr_next = rptr_inc;
                        rem_next  = rem_reg - POP_W'(1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot: fill on load, drop once taken
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            gok_reg       <= 1'b0;
            rem_reg       <= '0;
            pmoved_reg    <= '0;
            pfree_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            gok_reg       <= gok_next;
            rem_reg       <= rem_next;
            pmoved_reg    <= pmoved_next;
            pfree_reg     <= pfree_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload: load a new beat
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_out_reg   <= o_data;
            data_valid_reg <= o_dvalid;
            accepted_reg   <= o_acc;
            moved_reg      <= o_moved;
            free_reg       <= o_free;
            last_reg       <= o_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_out    = data_out_reg;
    assign data_valid  = data_valid_reg;
    assign accepted    = accepted_reg;
    assign moved_count = moved_reg;
    assign free_space  = free_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    // Store ports never write and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store written and read in the same cycle");

    // Pointers stay inside the store
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wptr_reg <= PTR_LAST) && (rptr_reg <= PTR_LAST))
        else $error("pointer outside the store");

    // A popped byte is always counted and accepted
    a_pop_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && data_valid_reg) |-> (accepted_reg && (moved_reg != '0)))
        else $error("popped byte without a move count");

    // Final popped byte returns the sequencer to idle
    a_pop_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && rem_reg == '0) |=> (state_reg == S_IDLE))
        else $error("pop did not finish after its final byte");
`endif

endmodule

`default_nettype wire
